### src/scalar_kalman_filter_range_switch_unit_defines.svh
// Assertion macros for the scalar Kalman filter range-switch unit.
`ifndef SCALAR_KALMAN_FILTER_RANGE_SWITCH_UNIT_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_RANGE_SWITCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SKFRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SKFRS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SKFRS_ASSERT_IMP(label, ante, cons, msg)
`define SKFRS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### src/skfrs_pkg.sv
// Shared widths, register indexes and constants of the Kalman filter unit.
`default_nettype none
package skfrs_pkg;
	localparam int SAMPLE_W      = 32;
	localparam int CFG_W         = 24;
	localparam int CFG_IDX_W     = 2;
	localparam int GAIN_BITS     = 16;
	localparam int GAIN_W        = GAIN_BITS + 1;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0]  Q_RESET  = CFG_W'(655);
	localparam logic [CFG_W-1:0]  R_RESET  = CFG_W'(16384);
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

	// divider: remainder width covers P + R, quotient covers 2*K + 1
	localparam int DIV_DW = SAMPLE_W + 1;
	localparam int DIV_QW = GAIN_BITS + 2;

	// multiplier: signed operand covers the innovation, unsigned the gain
	localparam int MUL_MW = SAMPLE_W + 2;
	localparam int MUL_NB = GAIN_W;
endpackage
`default_nettype wire

### src/skfrs_divider.sv
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module skfrs_divider import skfrs_pkg::*; #(
	parameter int DW = DIV_DW,
	parameter int QW = DIV_QW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] rem_init,
	input  logic [QW-1:0] shift_in,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quotient
);
	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [QW-1:0] ql_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          take;

	assign trial = {rem_q, ql_q[QW-1]};
	assign take  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			ql_q  <= shift_in;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DW-1:0] : trial[DW-1:0];
			ql_q  <= {ql_q[QW-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = ql_q;
endmodule
`default_nettype wire

### src/skfrs_serial_mul.sv
// Shift-add multiplier taking one multiplier bit per cycle, LSB first.
`default_nettype none
module skfrs_serial_mul import skfrs_pkg::*; #(
	parameter int MW = MUL_MW,
	parameter int NB = MUL_NB
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [MW-1:0] mcand,
	input  logic        [NB-1:0] mplier,
	output logic                 done,
	output logic signed [MW+NB:0] product
);
	localparam int CW = $clog2(NB + 1);

	logic signed [MW-1:0] mc_q;
	logic        [NB-1:0] mp_q;
	logic signed [MW:0]   hi_q;
	logic        [NB-1:0] lo_q;
	logic        [CW-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic signed [MW:0]   addend;
	logic signed [MW:0]   sum;

	assign addend = mp_q[0] ? {mc_q[MW-1], mc_q} : '0;
	assign sum    = hi_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// add the partial product, then shift the accumulator right one bit
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			mp_q <= mplier;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[NB-1:1]};
			mp_q <= mp_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};
endmodule
`default_nettype wire

### src/scalar_kalman_filter_range_switch_unit.sv
// One sample word is in flight at a time: sample_stall stays high from acceptance
// until its result word is written back. The bit-serial gain divider and the two
// bit-serial multipliers (run side by side) do the work in between.
// A result waiting on a stalled output holds the sequencer in its final write-back state.
// Reset (arst_n low, asynchronous): estimate 4.0, covariance 0.02, Q 0.01, R 0.25.
`default_nettype none
`include "scalar_kalman_filter_range_switch_unit_defines.svh"
module scalar_kalman_filter_range_switch_unit import skfrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [SAMPLE_W-1:0] estimate,
	output logic        [GAIN_W-1:0]   gain,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_MSTART = 3'd3;
	localparam logic [2:0] ST_MUL    = 3'd4;
	localparam logic [2:0] ST_FIN1   = 3'd5;
	localparam logic [2:0] ST_FIN2   = 3'd6;

	localparam int W   = SAMPLE_W;
	localparam int PW  = MUL_MW + MUL_NB + 1;
	localparam int UW  = PW - GAIN_BITS;
	localparam int SW  = UW + 1;

	localparam logic signed [W-1:0] FX_FOUR = W'(longint'(4) << FRAC_BITS);
	localparam logic signed [W-1:0] FX_FIVE = W'(longint'(5) << FRAC_BITS);
	localparam logic signed [W-1:0] FX_SIX  = W'(longint'(6) << FRAC_BITS);
	localparam logic [W-1:0] COV_RESET =
		W'(((longint'(1) << FRAC_BITS) * 2 + 50) / 100);
	localparam logic signed [W-1:0] EST_RESET = FX_FOUR;
	localparam logic signed [W-1:0] EST_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] EST_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (GAIN_BITS - 1);

	logic [2:0]            state_q;
	logic [CFG_W-1:0]      q_q;
	logic [CFG_W-1:0]      r_q;
	logic signed [W-1:0]   est_q;
	logic [W-1:0]          prior_q;

	logic signed [W-1:0]   sample_s1;
	logic signed [W-1:0]   est_sw_s1;
	logic [W-1:0]          p_s1;
	logic signed [W:0]     diff_s2;
	logic                  dz_s2;
	logic [GAIN_W-1:0]     k_s3;
	logic signed [UW-1:0]  upd_s4;
	logic [W-1:0]          np_s4;

	logic                  result_valid_q;
	logic signed [W-1:0]   estimate_q;
	logic [GAIN_W-1:0]     gain_q;

	logic                  accept;
	logic                  out_free;
	logic signed [W-1:0]   est_sw;
	logic [W:0]            p_sum;
	logic [W-1:0]          p_sat;
	logic [DIV_DW-1:0]     denom;
	logic                  div_done;
	logic [DIV_QW-1:0]     quot;
	logic [DIV_QW:0]       k_round;
	logic                  mul_start;
	logic                  mul_done;
	logic                  mul2_done;
	logic signed [PW-1:0]  prod1;
	logic signed [PW-1:0]  prod2;
	logic signed [PW-1:0]  prod1_rnd;
	logic [PW-1:0]         prod2_rnd;
	logic signed [SW-1:0]  est_sum;
	logic signed [W-1:0]   est_new;

	assign cfg_ready    = 1'b1;
	assign sample_stall = state_q != ST_IDLE;
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !result_valid_q || !result_stall;

	// range switch on the kept estimate; the sample 4.0 skips it
	always_comb begin
		est_sw = est_q;
		if (sample != FX_FOUR) begin
			if (sample > FX_FIVE) begin
				if (est_q < FX_SIX) begin
					if (est_q[W-1] != est_q[W-2])
						est_sw = est_q[W-1] ? EST_MIN : EST_MAX;
					else
						est_sw = {est_q[W-2:0], 1'b0};
				end
			end else if (est_q > FX_FIVE) begin
				est_sw = {1'b0, est_q[W-1:1]};
			end
		end
	end

	assign p_sum = {1'b0, prior_q} + (W + 1)'(q_q);
	assign p_sat = p_sum[W] ? '1 : p_sum[W-1:0];
	assign denom = DIV_DW'({1'b0, p_s1} + (W + 1)'(r_q));

	// round half up: K = (floor(P * 2^17 / (P + R)) + 1) / 2
	assign k_round = {1'b0, quot} + (DIV_QW + 1)'(1);

	assign mul_start = state_q == ST_MSTART;

	skfrs_divider #(
		.DW(DIV_DW),
		.QW(DIV_QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_PREP),
		.rem_init (DIV_DW'(p_s1 >> 1)),
		.shift_in ({p_s1[0], (DIV_QW - 1)'(0)}),
		.divisor  (denom),
		.done     (div_done),
		.quotient (quot)
	);

	skfrs_serial_mul #(
		.MW(MUL_MW),
		.NB(MUL_NB)
	) u_mul_upd (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (MUL_MW'(diff_s2)),
		.mplier  (k_s3),
		.done    (mul_done),
		.product (prod1)
	);

	skfrs_serial_mul #(
		.MW(MUL_MW),
		.NB(MUL_NB)
	) u_mul_cov (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   ($signed(MUL_MW'(p_s1))),
		.mplier  (GAIN_ONE - k_s3),
		.done    (mul2_done),
		.product (prod2)
	);

	assign prod1_rnd = prod1 + RND_HALF;
	assign prod2_rnd = $unsigned(prod2) + $unsigned(RND_HALF);
	assign est_sum   = SW'(est_sw_s1) + SW'(upd_s4);

	always_comb begin
		if (est_sum > SW'(EST_MAX))
			est_new = EST_MAX;
		else if (est_sum < SW'(EST_MIN))
			est_new = EST_MIN;
		else
			est_new = est_sum[W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= Q_RESET;
			r_q <= R_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PROCESS_NOISE: q_q <= cfg_data;
				REG_MEASURE_NOISE: r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			est_q          <= EST_RESET;
			prior_q        <= COV_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && state_q != ST_FIN2)
				result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:   if (accept) state_q <= ST_PREP;
				ST_PREP:   state_q <= ST_DIV;
				ST_DIV:    if (div_done) state_q <= ST_MSTART;
				ST_MSTART: state_q <= ST_MUL;
				ST_MUL:    if (mul_done && mul2_done) state_q <= ST_FIN1;
				ST_FIN1:   state_q <= ST_FIN2;
				ST_FIN2: begin
					// hold until the output register is free
					if (out_free) begin
						est_q          <= est_new;
						prior_q        <= np_s4;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			est_sw_s1 <= est_sw;
			p_s1      <= p_sat;
		end
		if (state_q == ST_PREP) begin
			diff_s2 <= (W + 1)'(sample_s1) - (W + 1)'(est_sw_s1);
			dz_s2   <= (p_s1 == '0) && (r_q == '0);
		end
		if (state_q == ST_DIV && div_done)
			k_s3 <= dz_s2 ? '0 : k_round[GAIN_W:1];
		if (state_q == ST_FIN1) begin
			upd_s4 <= prod1_rnd[PW-1:GAIN_BITS];
			np_s4  <= prod2_rnd[W+GAIN_BITS-1:GAIN_BITS];
		end
		if (state_q == ST_FIN2 && out_free) begin
			estimate_q <= est_new;
			gain_q     <= k_s3;
		end
	end

	assign result_valid = result_valid_q;
	assign estimate     = estimate_q;
	assign gain         = gain_q;

	`SKFRS_ASSERT_IMP(a_div_done_phase, div_done, state_q == ST_DIV, "divider done outside divide phase")
	`SKFRS_ASSERT_IMP(a_mul_lockstep, mul_done != mul2_done, 1'b0, "multipliers out of step")
	`SKFRS_ASSERT_IMP(a_gain_range, result_valid, gain <= GAIN_ONE, "gain above one")
	`SKFRS_ASSERT_NXT(a_result_loads, state_q == ST_FIN2 && out_free, result_valid, "result word not loaded")
endmodule
`default_nettype wire

### test/scalar_kalman_filter_range_switch_unit_tb.sv
// Self-checking testbench for the scalar Kalman filter range-switch unit.
`timescale 1ns / 100ps
module scalar_kalman_filter_range_switch_unit_tb;
	import skfrs_pkg::*;

	localparam int unsigned LIMIT_CYCLES  = 400000;
	localparam int          SETTLE_CYCLES = 60;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

	localparam logic signed [SAMPLE_W-1:0] FX_FOUR   = SAMPLE_W'(4) << FRAC_BITS_DEF;
	localparam logic signed [SAMPLE_W-1:0] FX_FIVE   = SAMPLE_W'(5) << FRAC_BITS_DEF;
	localparam logic signed [SAMPLE_W-1:0] FX_SIX    = SAMPLE_W'(6) << FRAC_BITS_DEF;
	localparam logic signed [SAMPLE_W-1:0] FX_SEVEN  = SAMPLE_W'(7) << FRAC_BITS_DEF;
	localparam logic signed [SAMPLE_W-1:0] FX_TWELVE = SAMPLE_W'(12) << FRAC_BITS_DEF;
	localparam logic signed [SAMPLE_W-1:0] FX_MIN    = 32'sh8000_0000;
	localparam logic signed [SAMPLE_W-1:0] FX_MAX    = 32'sh7FFF_FFFF;

	localparam logic [SAMPLE_W-1:0] COV_RESET =
		SAMPLE_W'(((64'd1 << FRAC_BITS_DEF) * 2 + 50) / 100);
	localparam longint unsigned COV_MAX    = 64'hFFFF_FFFF;
	localparam longint unsigned GAIN_UNITY = 64'd1 << GAIN_BITS;
	localparam logic [CFG_W-1:0] CFG_TOP   = {CFG_W{1'b1}};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] est;
		logic        [GAIN_W-1:0]   k;
	} filter_word_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] estimate;
	logic        [GAIN_W-1:0]   gain;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;

	// filter state and noise settings as the block should hold them
	logic signed [SAMPLE_W-1:0] kept_est;
	logic        [SAMPLE_W-1:0] kept_cov;
	logic        [CFG_W-1:0]    q_cov;
	logic        [CFG_W-1:0]    r_cov;

	logic signed [SAMPLE_W-1:0] sample_pending[$];
	filter_word_t               estimate_due[$];
	filter_word_t               oldest;

	logic        idle_on = 1'b1;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;

	scalar_kalman_filter_range_switch_unit #(
		.FRAC_BITS(FRAC_BITS_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.estimate(estimate),
		.gain(gain),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp32(input longint v);
		if (v > longint'(FX_MAX))
			return longint'(FX_MAX);
		if (v < longint'(FX_MIN))
			return longint'(FX_MIN);
		return v;
	endfunction

	// range switch, then predict, gain, update; advances the kept state
	function automatic filter_word_t advance_filter(input logic signed [SAMPLE_W-1:0] smp);
		filter_word_t     res;
		longint           s;
		longint           e;
		longint           innov;
		longint unsigned  p;
		longint unsigned  den;
		longint unsigned  k;
		longint unsigned  np;
		s = smp;
		e = kept_est;
		if (smp != FX_FOUR) begin
			if (smp > FX_FIVE) begin
				if (e < FX_SIX)
					e = clamp32(e * 2);
			end else if (e > FX_FIVE) begin
				e = e >>> 1;
			end
		end
		p = 64'(kept_cov) + 64'(q_cov);
		if (p > COV_MAX)
			p = COV_MAX;
		den = p + 64'(r_cov);
		k = (den == 0) ? 64'd0 : ((p << GAIN_BITS) + den / 2) / den;
		if (k > GAIN_UNITY)
			k = GAIN_UNITY;
		innov = longint'(k) * (s - e);
		e = clamp32(e + ((innov + (longint'(1) <<< (GAIN_BITS - 1))) >>> GAIN_BITS));
		np = ((GAIN_UNITY - k) * p + (GAIN_UNITY >> 1)) >> GAIN_BITS;
		if (np > COV_MAX)
			np = COV_MAX;
		kept_est = e[SAMPLE_W-1:0];
		kept_cov = np[SAMPLE_W-1:0];
		res.est = e[SAMPLE_W-1:0];
		res.k = k[GAIN_W-1:0];
		return res;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] draw_sample();
		int unsigned                pick;
		logic signed [SAMPLE_W-1:0] base;
		pick = $urandom_range(0, 9);
		case ($urandom_range(0, 2))
		0: base = FX_FOUR;
		1: base = FX_FIVE;
		default: base = FX_SIX;
		endcase
		if (pick < 2)
			return $urandom();
		if (pick == 2)
			return FX_FOUR;
		if (pick == 3)
			return base + SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
		if (pick == 4) begin
			case ($urandom_range(0, 3))
			0: return FX_MIN;
			1: return FX_MAX;
			2: return '0;
			default: return '1;
			endcase
		end
		// moderate values keep the estimate near the switch thresholds
		return SAMPLE_W'($urandom_range(0, 24 << FRAC_BITS_DEF)) - FX_TWELVE;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		REG_PROCESS_NOISE: q_cov = val;
		REG_MEASURE_NOISE: r_cov = val;
		default: ;
		endcase
	endtask

	// hold the sender until every queued word went in and every result came out
	task automatic drain();
		do @(posedge clk);
		while (sample_pending.size() != 0 || sample_valid || estimate_due.size() != 0);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] q, input logic [CFG_W-1:0] r,
			input int n, input logic idle);
		write_reg(REG_PROCESS_NOISE, q);
		write_reg(REG_MEASURE_NOISE, r);
		idle_on = idle;
		repeat (n) sample_pending.push_back(draw_sample());
		drain();
	endtask

	// sample driver; predicts each word as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			send_gap <= 0;
		end else begin
			if (sample_valid && !sample_stall)
				estimate_due.push_back(advance_filter(sample));
			if (!sample_valid || !sample_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					sample_valid <= 1'b0;
				end else if (sample_pending.size() != 0 && idle_on
						&& $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 7);
					sample_valid <= 1'b0;
				end else if (sample_pending.size() != 0) begin
					sample <= sample_pending.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 7);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (estimate_due.size() == 0) begin
				$display("%0t: unexpected result word, estimate %0d gain %0d",
					$time, estimate, gain);
				mismatches++;
			end else begin
				oldest = estimate_due.pop_front();
				if (estimate !== oldest.est) begin
					$display("%0t: estimate mismatch, expected %0d, actual %0d",
						$time, oldest.est, estimate);
					mismatches++;
				end
				if (gain !== oldest.k) begin
					$display("%0t: gain mismatch, expected %0d, actual %0d",
						$time, oldest.k, gain);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("scalar_kalman_filter_range_switch_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		kept_est = FX_FOUR;
		kept_cov = COV_RESET;
		q_cov = Q_RESET;
		r_cov = R_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// switch rule under the reset noise settings, estimate starting at 4.0
		sample_pending.push_back(FX_FOUR);
		sample_pending.push_back(FX_FIVE);
		sample_pending.push_back(FX_FIVE + 1);
		sample_pending.push_back(FX_SEVEN);
		sample_pending.push_back(FX_FIVE);
		sample_pending.push_back('0);
		sample_pending.push_back('1);
		sample_pending.push_back(FX_MAX);
		sample_pending.push_back(FX_FOUR);
		sample_pending.push_back(FX_FIVE);
		sample_pending.push_back(FX_MIN);
		drain();

		// full gain: estimate follows the sample, doubling clips at the bottom
		write_reg(REG_PROCESS_NOISE, CFG_TOP);
		write_reg(REG_MEASURE_NOISE, CFG_W'(1));
		sample_pending.push_back(FX_MIN);
		sample_pending.push_back(FX_MAX);
		sample_pending.push_back(FX_FOUR);
		sample_pending.push_back(FX_MIN);
		sample_pending.push_back(FX_SIX);
		sample_pending.push_back(FX_MAX);
		sample_pending.push_back(FX_FIVE);
		sample_pending.push_back(SAMPLE_W'(1));
		sample_pending.push_back(FX_SIX - 1);
		sample_pending.push_back(FX_SEVEN);
		drain();

		// spare indexes must leave the noise settings alone
		write_reg(REG_SPARE_2, CFG_W'($urandom()));
		write_reg(REG_SPARE_3, CFG_W'($urandom()));

		run_phase('0, CFG_W'(1), 90, 1'b1);
		run_phase(CFG_TOP, CFG_TOP, 90, 1'b1);
		write_reg(REG_SPARE_3, CFG_TOP);
		run_phase('0, CFG_TOP, 90, 1'b1);
		run_phase(CFG_W'($urandom_range(0, CFG_TOP)), CFG_W'($urandom_range(1, CFG_TOP)),
			90, 1'b1);
		run_phase(Q_RESET, R_RESET, 90, 1'b0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && estimate_due.size() == 0) begin
			$display("scalar_kalman_filter_range_switch_unit_tb: done, clean");
		end else begin
			$display("scalar_kalman_filter_range_switch_unit_tb: done, errors");
		end
		$finish;
	end
endmodule

### scalar_kalman_filter_range_switch_unit.f
+incdir+src
src/skfrs_pkg.sv
src/skfrs_divider.sv
src/skfrs_serial_mul.sv
src/scalar_kalman_filter_range_switch_unit.sv
test/scalar_kalman_filter_range_switch_unit_tb.sv
